/* rtl/urfrx_pkg.sv */
// Shared types and constants for the UART register file with receive FIFO.
`timescale 1ns / 1ps

package urfrx_pkg;

    // Receive FIFO geometry
    localparam int FIFO_DEPTH = 256;
    localparam int ADDR_W     = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int FILL_W     = $clog2(FIFO_DEPTH + 1);
    localparam int PSUM_W     = ADDR_W + 1;

    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_RX    = 2'd1,
        ACT_READ  = 2'd2,
        ACT_WRITE = 2'd3
    } t_action;

    // Register offsets
    localparam logic [2:0] OFS_RBR = 3'd0;  // RBR / THR
    localparam logic [2:0] OFS_IER = 3'd1;
    localparam logic [2:0] OFS_IIR = 3'd2;  // IIR / FCR
    localparam logic [2:0] OFS_LCR = 3'd3;
    localparam logic [2:0] OFS_MCR = 3'd4;
    localparam logic [2:0] OFS_LSR = 3'd5;
    localparam logic [2:0] OFS_MSR = 3'd6;

    // IIR codes
    localparam logic [7:0] IIR_RX_DATA  = 8'h04;
    localparam logic [7:0] IIR_TX_EMPTY = 8'h02;
    localparam logic [7:0] IIR_NONE     = 8'h01;

    // LSR bits
    localparam logic [7:0] LSR_DR   = 8'h01;
    localparam logic [7:0] LSR_IDLE = 8'h60;  // THRE | TEMT

    localparam logic [7:0] LCR_RESET  = 8'h03;  // 8N1
    localparam logic [7:0] BUSY_RESET = 8'd64;
    localparam logic [3:0] IER_MASK   = 4'hF;

    typedef struct packed {
        t_action    action;
        logic [2:0] offset;
        logic [7:0] data;
    } t_in_req;

    typedef struct packed {
        logic [7:0] read_data;
        logic       irq;
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       rx_dropped;
    } t_out_rsp;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_POP  = 2'b10
    } t_state;

endpackage

/* rtl/urfrx_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module urfrx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/uart_register_file_rx_fifo.sv */
// Top level: simplified 16550 register file with a RAM-backed receive FIFO.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+-----------------------------
//  in      | input     | i_in_valid / o_in_stall    | i_in_req  (action, offset, data)
//  out     | output    | o_out_valid / i_out_stall  | o_out_rsp (read_data, irq, tx...)
//  cfg     | input     | i_cfg_we                   | i_cfg_wdata (tx_busy_ticks)
//
// Every request gives exactly one response. For ticks, received bytes, writes
// and reads other than a popping RBR read, the response is registered and a
// new request is taken in the next cycle unless the response is stalled. An RBR
// read that pops the FIFO waits in ST_POP for the registered read data of the
// FIFO RAM. Reset (synchronous, active low) clears all control registers; the
// FIFO RAM is not cleared since only written entries are ever read. A stalled
// response holds in the output register and blocks new requests until taken.
`timescale 1ns / 1ps

module uart_register_file_rx_fifo (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  urfrx_pkg::t_in_req i_in_req,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output urfrx_pkg::t_out_rsp o_out_rsp,
    input  logic               i_cfg_we,
    input  logic [7:0]         i_cfg_wdata
);

    // Control / architectural registers
    urfrx_pkg::t_state                 r_state, n_state;
    logic [urfrx_pkg::ADDR_W-1:0]      r_rd_pos, n_rd_pos;
    logic [urfrx_pkg::FILL_W-1:0]      r_rx_fill, n_rx_fill;
    logic [3:0]                        r_ier, n_ier;
    logic [7:0]                        r_lcr, n_lcr;
    logic [7:0]                        r_mcr, n_mcr;
    logic [7:0]                        r_scr, n_scr;
    logic                              r_tx_busy, n_tx_busy;
    logic [7:0]                        r_tx_cd, n_tx_cd;
    logic [7:0]                        r_busy_ticks;
    logic                              r_out_valid, n_out_valid;
    urfrx_pkg::t_out_rsp               r_out, n_out;

    // FIFO RAM port
    logic                              ram_we;
    logic [urfrx_pkg::ADDR_W-1:0]      ram_waddr;
    logic [7:0]                        ram_rdata;

    logic                              in_acc;
    logic                              dlab;
    logic                              fifo_full;
    logic                              fifo_empty;
    logic [urfrx_pkg::PSUM_W-1:0]      wr_sum;
    logic [urfrx_pkg::PSUM_W-1:0]      wr_pos;
    logic                              pop;
    logic [7:0]                        rd_val;
    logic                              tx_v;
    logic                              dropped;

    // Pops wait in ST_POP for RAM data; a held response blocks new requests
    assign o_in_stall = (r_state == urfrx_pkg::ST_POP) || (r_out_valid && i_out_stall);
    assign in_acc     = i_in_valid && !o_in_stall;

    assign dlab       = r_lcr[7];
    assign fifo_full  = (r_rx_fill == urfrx_pkg::FILL_W'(urfrx_pkg::FIFO_DEPTH));
    assign fifo_empty = (r_rx_fill == '0);

    // Tail position: read position plus fill, wrapped at the depth
    assign wr_sum = urfrx_pkg::PSUM_W'(r_rd_pos) + urfrx_pkg::PSUM_W'(r_rx_fill);
    assign wr_pos = (wr_sum >= urfrx_pkg::PSUM_W'(urfrx_pkg::FIFO_DEPTH))
                  ? wr_sum - urfrx_pkg::PSUM_W'(urfrx_pkg::FIFO_DEPTH) : wr_sum;
    assign ram_waddr = wr_pos[urfrx_pkg::ADDR_W-1:0];

    urfrx_ram #(
        .WIDTH (8),
        .DEPTH (urfrx_pkg::FIFO_DEPTH)
    ) u_rx_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_in_req.data),
        .i_raddr (r_rd_pos),   // head entry, read every cycle
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state     = r_state;
        n_rd_pos    = r_rd_pos;
        n_rx_fill   = r_rx_fill;
        n_ier       = r_ier;
        n_lcr       = r_lcr;
        n_mcr       = r_mcr;
        n_scr       = r_scr;
        n_tx_busy   = r_tx_busy;
        n_tx_cd     = r_tx_cd;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        ram_we      = 1'b0;
        pop         = 1'b0;
        rd_val      = '0;
        tx_v        = 1'b0;
        dropped     = 1'b0;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        // ST_POP: head byte is now out of the RAM
        if (r_state == urfrx_pkg::ST_POP) begin
            n_out.read_data = ram_rdata;
            n_out_valid     = 1'b1;
            n_state         = urfrx_pkg::ST_IDLE;
        end

        if (in_acc) begin
            case (i_in_req.action)
                urfrx_pkg::ACT_TICK: begin
                    if (r_tx_busy) begin
                        n_tx_cd = r_tx_cd - 8'd1;
                        if (r_tx_cd == 8'd1) begin
                            n_tx_busy = 1'b0;
                        end
                    end
                end
                urfrx_pkg::ACT_RX: begin
                    if (fifo_full) begin
                        dropped = 1'b1;
                    end else begin
                        ram_we    = 1'b1;
                        n_rx_fill = r_rx_fill + urfrx_pkg::FILL_W'(1);
                    end
                end
                urfrx_pkg::ACT_READ: begin
                    case (i_in_req.offset)
                        urfrx_pkg::OFS_RBR: begin
                            if (!dlab && !fifo_empty) begin
                                pop       = 1'b1;
                                n_rx_fill = r_rx_fill - urfrx_pkg::FILL_W'(1);
                                if (r_rd_pos == urfrx_pkg::ADDR_W'(urfrx_pkg::FIFO_DEPTH - 1)) begin
                                    n_rd_pos = '0;
                                end else begin
                                    n_rd_pos = r_rd_pos + urfrx_pkg::ADDR_W'(1);
                                end
                            end
                        end
                        urfrx_pkg::OFS_IER: rd_val = dlab ? 8'h00 : {4'h0, r_ier};
                        urfrx_pkg::OFS_IIR: begin
                            if (!fifo_empty && r_ier[0]) begin
                                rd_val = urfrx_pkg::IIR_RX_DATA;
                            end else if (!r_tx_busy && r_ier[1]) begin
                                rd_val = urfrx_pkg::IIR_TX_EMPTY;
                            end else begin
                                rd_val = urfrx_pkg::IIR_NONE;
                            end
                        end
                        urfrx_pkg::OFS_LCR: rd_val = r_lcr;
                        urfrx_pkg::OFS_MCR: rd_val = r_mcr;
                        urfrx_pkg::OFS_LSR: begin
                            rd_val = (r_tx_busy ? 8'h00 : urfrx_pkg::LSR_IDLE)
                                   | (fifo_empty ? 8'h00 : urfrx_pkg::LSR_DR);
                        end
                        urfrx_pkg::OFS_MSR: rd_val = 8'h00;
                        default:            rd_val = r_scr;
                    endcase
                end
                default: begin
                    case (i_in_req.offset)
                        urfrx_pkg::OFS_RBR: begin
                            if (!dlab) begin
                                tx_v      = 1'b1;
                                n_tx_busy = 1'b1;
                                n_tx_cd   = r_busy_ticks;
                            end
                        end
                        urfrx_pkg::OFS_IER: n_ier = i_in_req.data[3:0] & urfrx_pkg::IER_MASK;
                        urfrx_pkg::OFS_IIR: ;   // FCR: no effect
                        urfrx_pkg::OFS_LCR: n_lcr = i_in_req.data;
                        urfrx_pkg::OFS_MCR: n_mcr = i_in_req.data;
                        default:            n_scr = i_in_req.data;
                    endcase
                end
            endcase

            n_out.read_data  = rd_val;
            n_out.irq        = ((n_rx_fill != '0) && n_ier[0]) || (!n_tx_busy && n_ier[1]);
            n_out.tx_valid   = tx_v;
            n_out.tx_byte    = tx_v ? i_in_req.data : 8'h00;
            n_out.rx_dropped = dropped;
            n_out_valid      = !pop;
            if (pop) begin
                n_state = urfrx_pkg::ST_POP;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= urfrx_pkg::ST_IDLE;
            r_rd_pos     <= '0;
            r_rx_fill    <= '0;
            r_ier        <= '0;
            r_lcr        <= urfrx_pkg::LCR_RESET;
            r_mcr        <= '0;
            r_scr        <= '0;
            r_tx_busy    <= 1'b0;
            r_tx_cd      <= '0;
            r_busy_ticks <= urfrx_pkg::BUSY_RESET;
            r_out_valid  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rd_pos    <= n_rd_pos;
            r_rx_fill   <= n_rx_fill;
            r_ier       <= n_ier;
            r_lcr       <= n_lcr;
            r_mcr       <= n_mcr;
            r_scr       <= n_scr;
            r_tx_busy   <= n_tx_busy;
            r_tx_cd     <= n_tx_cd;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_busy_ticks <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out;

    // Fill count never exceeds the FIFO depth
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rx_fill <= urfrx_pkg::FILL_W'(urfrx_pkg::FIFO_DEPTH))
        else $error("rx fill above depth");

    // Read position stays inside the FIFO
    a_rdpos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        urfrx_pkg::PSUM_W'(r_rd_pos) < urfrx_pkg::PSUM_W'(urfrx_pkg::FIFO_DEPTH))
        else $error("rx read position out of range");

    // A pop always delivers its response in the following cycle
    a_pop_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == urfrx_pkg::ST_POP) |=> (r_out_valid && r_state == urfrx_pkg::ST_IDLE))
        else $error("pop response not delivered");

    // An emitted byte leaves the transmitter busy
    a_tx_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.tx_valid) |-> r_tx_busy)
        else $error("tx byte without busy transmitter");

endmodule
